>>> rtl/etbv_pkg.sv
package etbv_pkg;

    localparam int WORK_FRAC = 30;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;

    typedef struct packed {
        logic [15:0] yaw_angle;
        logic [15:0] pitch_angle;
        logic [15:0] roll_angle;
    } etbv_in_t;

    typedef struct packed {
        logic signed [15:0] forward_x;
        logic signed [15:0] forward_y;
        logic signed [15:0] forward_z;
        logic signed [15:0] side_x;
        logic signed [15:0] side_y;
        logic signed [15:0] side_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
    } etbv_out_t;

    // arctangent of 2^-i in 2^-32 turn units
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // Q30 product, rounded half up
    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b + (64'sd1 <<< (WORK_FRAC - 1));
        return p[61:30];
    endfunction

endpackage

>>> rtl/etbv_cordic.sv
module etbv_cordic
    import etbv_pkg::*;
#(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic [ANGLE_BITS-1:0]   angle,
    output logic signed [31:0]      sin_q,
    output logic signed [31:0]      cos_q
);

    logic [31:0] a32;
    logic [31:0] turn;
    assign a32  = {angle, {(32-ANGLE_BITS){1'b0}}};
    assign turn = a32 + 32'h20000000;

    logic signed [33:0] x_reg [CORDIC_STAGES+1];
    logic signed [33:0] y_reg [CORDIC_STAGES+1];
    logic signed [33:0] z_reg [CORDIC_STAGES+1];
    logic [1:0]         q_reg [CORDIC_STAGES+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= CORDIC_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= $signed({4'b0000, turn[29:0]}) - 34'sd536870912;
            q_reg[0] <= turn[31:30];
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        logic signed [33:0] at;
        assign at = $signed({2'b00, atan_turn(5'(i))});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][33])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - at;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + at;
                end
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    logic signed [33:0] xf, yf, nxf, nyf;
    logic signed [31:0] sin_reg, cos_reg;
    assign xf  = x_reg[CORDIC_STAGES];
    assign yf  = y_reg[CORDIC_STAGES];
    assign nxf = -xf;
    assign nyf = -yf;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            case (q_reg[CORDIC_STAGES])
                2'd0:
                begin
                    cos_reg <= xf[31:0];
                    sin_reg <= yf[31:0];
                end
                2'd1:
                begin
                    cos_reg <= nyf[31:0];
                    sin_reg <= xf[31:0];
                end
                2'd2:
                begin
                    cos_reg <= nxf[31:0];
                    sin_reg <= nyf[31:0];
                end
                default:
                begin
                    cos_reg <= yf[31:0];
                    sin_reg <= nxf[31:0];
                end
            endcase
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

>>> rtl/euler_to_basis_vectors.sv
// Euler angles to forward / side / up basis vectors.
// Input channel: in_valid, in_stall, in_data (yaw, pitch, roll binary angles).
// Output channel: out_valid, out_stall, out_data (nine Q1.14 components).
// Config channel: cfg_valid, cfg_ready, cfg_data; cfg_ready is always high.
// cfg_data = 0 gives the right vector, 1 the negated (left) vector.
// Write it only while no request is in flight.
// Pipeline from request to result: angle prep, one CORDIC iteration
// per stage, quadrant fix-up, two multiply stages, and a sum / round /
// saturate stage.
// Throughput: one request per cycle while out_stall does not hold the
// pipeline; the three sine/cosine pipelines and the product stages are fully pipelined.
// When out_stall is high with a result pending, the whole pipeline holds
// and in_stall rises; nothing is dropped or repeated.
// Reset empties the pipeline and clears side select to 0.
module euler_to_basis_vectors
    import etbv_pkg::*;
#(
    parameter int ANGLE_BITS    = 16,
    parameter int FRAC_BITS     = 14,
    parameter int CORDIC_STAGES = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  etbv_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output etbv_out_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    localparam int LAT = CORDIC_STAGES + 5;
    localparam int SH  = WORK_FRAC - FRAC_BITS;
    localparam logic signed [35:0] RND = (SH > 0) ? (36'sd1 <<< (SH - 1)) : 36'sd0;
    localparam logic signed [35:0] LIM = 36'sd1 <<< FRAC_BITS;

    function automatic logic signed [35:0] to_out(input logic signed [33:0] v);
        logic signed [35:0] r;
        r = (36'(v) + RND) >>> SH;
        if (r > LIM)
            r = LIM;
        if (r < -LIM)
            r = -LIM;
        return r;
    endfunction

    logic en;
    logic side_select_reg;
    logic [LAT-1:0] vld_reg, vld_next;

    assign en        = !(vld_reg[LAT-1] && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;
    assign out_valid = vld_reg[LAT-1];
    assign vld_next  = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg         <= '0;
            side_select_reg <= 1'b0;
        end
        else
        begin
            if (en)
                vld_reg <= vld_next;
            if (cfg_valid)
                side_select_reg <= cfg_data;
        end
    end

    logic [ANGLE_BITS+15:0] yaw_ext, pitch_ext, roll_ext;
    assign yaw_ext   = {{ANGLE_BITS{1'b0}}, in_data.yaw_angle};
    assign pitch_ext = {{ANGLE_BITS{1'b0}}, in_data.pitch_angle};
    assign roll_ext  = {{ANGLE_BITS{1'b0}}, in_data.roll_angle};

    logic signed [31:0] sy, cy, sp, cp, sr, cr;

    etbv_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
        .clk(clk), .en(en), .angle(yaw_ext[ANGLE_BITS-1:0]), .sin_q(sy), .cos_q(cy)
    );
    etbv_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
        .clk(clk), .en(en), .angle(pitch_ext[ANGLE_BITS-1:0]), .sin_q(sp), .cos_q(cp)
    );
    etbv_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
        .clk(clk), .en(en), .angle(roll_ext[ANGLE_BITS-1:0]), .sin_q(sr), .cos_q(cr)
    );

    // first product stage
    logic signed [31:0] srsp_reg, crsp_reg, cpcy_reg, cpsy_reg, srcp_reg, crcp_reg;
    logic signed [31:0] crsy_reg, crcy_reg, srsy_reg, srcy_reg, sp_reg, cy_reg, sy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srsp_reg <= mulq(sr, sp);
            crsp_reg <= mulq(cr, sp);
            cpcy_reg <= mulq(cp, cy);
            cpsy_reg <= mulq(cp, sy);
            srcp_reg <= mulq(sr, cp);
            crcp_reg <= mulq(cr, cp);
            crsy_reg <= mulq(cr, sy);
            crcy_reg <= mulq(cr, cy);
            srsy_reg <= mulq(sr, sy);
            srcy_reg <= mulq(sr, cy);
            sp_reg   <= sp;
            cy_reg   <= cy;
            sy_reg   <= sy;
        end
    end

    // second product stage: three-factor terms
    logic signed [31:0] a1_reg, a2_reg, a3_reg, a4_reg;
    logic signed [31:0] cpcy2_reg, cpsy2_reg, srcp2_reg, crcp2_reg;
    logic signed [31:0] crsy2_reg, crcy2_reg, srsy2_reg, srcy2_reg, sp2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg    <= mulq(srsp_reg, cy_reg);
            a2_reg    <= mulq(srsp_reg, sy_reg);
            a3_reg    <= mulq(crsp_reg, cy_reg);
            a4_reg    <= mulq(crsp_reg, sy_reg);
            cpcy2_reg <= cpcy_reg;
            cpsy2_reg <= cpsy_reg;
            srcp2_reg <= srcp_reg;
            crcp2_reg <= crcp_reg;
            crsy2_reg <= crsy_reg;
            crcy2_reg <= crcy_reg;
            srsy2_reg <= srsy_reg;
            srcy2_reg <= srcy_reg;
            sp2_reg   <= sp_reg;
        end
    end

    // sums, rounding, saturation
    logic signed [35:0] fx, fy, fz, rx, ry, rz, ux, uy, uz, sx, sy_o, sz;

    always_comb
    begin
        fx = to_out(34'(cpcy2_reg));
        fy = to_out(34'(cpsy2_reg));
        fz = to_out(-34'(sp2_reg));
        rx = to_out(-34'(a1_reg) + 34'(crsy2_reg));
        ry = to_out(-34'(a2_reg) - 34'(crcy2_reg));
        rz = to_out(-34'(srcp2_reg));
        ux = to_out(34'(a3_reg) + 34'(srsy2_reg));
        uy = to_out(34'(a4_reg) - 34'(srcy2_reg));
        uz = to_out(34'(crcp2_reg));
        sx   = side_select_reg ? -rx : rx;
        sy_o = side_select_reg ? -ry : ry;
        sz   = side_select_reg ? -rz : rz;
    end

    etbv_out_t out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.forward_x <= fx[15:0];
            out_reg.forward_y <= fy[15:0];
            out_reg.forward_z <= fz[15:0];
            out_reg.side_x    <= sx[15:0];
            out_reg.side_y    <= sy_o[15:0];
            out_reg.side_z    <= sz[15:0];
            out_reg.up_x      <= ux[15:0];
            out_reg.up_y      <= uy[15:0];
            out_reg.up_z      <= uz[15:0];
        end
    end

    assign out_data = out_reg;

endmodule
